### hw/rtl/thcd_pkg.sv
// Shared types, widths and codes for the tactile high-pass contact detector.
`default_nettype none

package thcd_pkg;

    localparam int LANES       = 5;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int FILT_BITS   = 24;
    localparam int HOLD_BITS   = 10;
    localparam int ALPHA_BITS  = 16;
    localparam int THR_BITS    = 16;
    localparam int KIND_BITS   = 2;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TERM   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_SET     = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_HOLD    = 2'd3;

    localparam logic [ALPHA_BITS-1:0]    ALPHA_RESET   = 16'd59578;
    localparam logic signed [THR_BITS-1:0] SET_RESET   = -16'sd20;
    localparam logic signed [THR_BITS-1:0] REL_RESET   = 16'sd100;
    localparam logic [HOLD_BITS-1:0]     HOLD_RESET    = 10'd100;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [FILT_BITS-1:0]   t_filt;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]      alpha;
        logic signed [THR_BITS-1:0] set_thr;
        logic signed [THR_BITS-1:0] rel_thr;
        logic [HOLD_BITS-1:0]       hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic step;       // item accepted this cycle
        logic sample_en;  // run the filter
        logic latch_en;   // update the latch from the filter output
        logic latch_clr;  // force the latch clear
    } t_lane_ctrl;

    typedef struct packed {
        logic [LANES-1:0]  contact;
        t_filt [LANES-1:0] filtered;
        logic              hold_active;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/thcd_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none

interface thcd_in_if import thcd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    t_sample              sample_a;
    t_sample              sample_b;
    t_sample              sample_c;
    t_sample              sample_d;
    t_sample              sample_e;

    modport source (
        output valid, kind, sample_a, sample_b, sample_c, sample_d, sample_e,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_a, sample_b, sample_c, sample_d, sample_e,
        output ready
    );
endinterface

interface thcd_out_if import thcd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  contact_a;
    logic  contact_b;
    logic  contact_c;
    logic  contact_d;
    logic  contact_e;
    t_filt filtered_a;
    t_filt filtered_b;
    t_filt filtered_c;
    t_filt filtered_d;
    t_filt filtered_e;
    logic  hold_active;

    modport source (
        output valid, contact_a, contact_b, contact_c, contact_d, contact_e,
               filtered_a, filtered_b, filtered_c, filtered_d, filtered_e, hold_active,
        input  ready
    );
    modport sink (
        input  valid, contact_a, contact_b, contact_c, contact_d, contact_e,
               filtered_a, filtered_b, filtered_c, filtered_d, filtered_e, hold_active,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/thcd_regs.sv
// APB-style configuration registers.
`default_nettype none

module thcd_regs import thcd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha      <= ALPHA_RESET;
            r_cfg.set_thr    <= SET_RESET;
            r_cfg.rel_thr    <= REL_RESET;
            r_cfg.hold_ticks <= HOLD_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ALPHA:   r_cfg.alpha      <= pwdata[ALPHA_BITS-1:0];
                REG_SET:     r_cfg.set_thr    <= $signed(pwdata[THR_BITS-1:0]);
                REG_RELEASE: r_cfg.rel_thr    <= $signed(pwdata[THR_BITS-1:0]);
                REG_HOLD:    r_cfg.hold_ticks <= pwdata[HOLD_BITS-1:0];
                default:     r_cfg.alpha      <= r_cfg.alpha;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ALPHA:   prdata = DATA_BITS'(r_cfg.alpha);
            REG_SET:     prdata = DATA_BITS'(r_cfg.set_thr);
            REG_RELEASE: prdata = DATA_BITS'(r_cfg.rel_thr);
            REG_HOLD:    prdata = DATA_BITS'(r_cfg.hold_ticks);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/thcd_lane.sv
// One channel: fixed-point high-pass filter with saturation and contact latch.
`default_nettype none

module thcd_lane import thcd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_lane_ctrl i_ctrl,
    input  wire t_cfg       i_cfg,
    input  wire t_sample    i_sample,
    output t_filt           o_y_next,
    output logic            o_latch_next,
    output logic            o_latch
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SUM_W  = (DIFF_W + FRAC_BITS > FILT_BITS ? DIFF_W + FRAC_BITS : FILT_BITS) + 1;
    localparam int PROD_W = SUM_W + ALPHA_BITS + 1;
    localparam logic signed [PROD_W-1:0] RND    = PROD_W'(1) <<< (ALPHA_BITS - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (FILT_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(2 ** (FILT_BITS - 1)));

    t_sample                   r_prev;
    t_filt                     r_y;
    logic                      r_latch;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   sum;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rnd;
    t_filt                     y_filt;
    t_filt                     set_scaled;
    t_filt                     rel_scaled;
    logic                      latch_set;

    always_comb begin
        diff = DIFF_W'(i_sample) - DIFF_W'(r_prev);
        sum  = SUM_W'(r_y) + (SUM_W'(diff) <<< FRAC_BITS);
        prod = PROD_W'(sum) * PROD_W'($signed({1'b0, i_cfg.alpha}));
        // arithmetic shift gives floor, so halves round toward +inf
        rnd  = (prod + RND) >>> ALPHA_BITS;
        priority if (rnd > SAT_HI) begin
            y_filt = SAT_HI[FILT_BITS-1:0];
        end else if (rnd < SAT_LO) begin
            y_filt = SAT_LO[FILT_BITS-1:0];
        end else begin
            y_filt = rnd[FILT_BITS-1:0];
        end
    end

    assign set_scaled = FILT_BITS'(i_cfg.set_thr) <<< FRAC_BITS;
    assign rel_scaled = FILT_BITS'(i_cfg.rel_thr) <<< FRAC_BITS;
    assign latch_set  = r_latch | (y_filt < set_scaled);

    always_comb begin
        o_y_next = i_ctrl.sample_en ? y_filt : r_y;
        priority if (i_ctrl.latch_clr) begin
            o_latch_next = 1'b0;
        end else if (i_ctrl.latch_en) begin
            o_latch_next = latch_set & ~(y_filt > rel_scaled);
        end else begin
            o_latch_next = r_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_y     <= '0;
            r_latch <= 1'b0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.sample_en) begin
                r_prev <= i_sample;
            end
            r_y     <= o_y_next;
            r_latch <= o_latch_next;
        end
    end

    assign o_latch = r_latch;

endmodule

`default_nettype wire

### hw/rtl/tactile_highpass_contact_detect.sv
// Top level: five filter lanes, hold counter, result merge and output queue.
//
// Input items arrive on i_in (kind plus five signed samples); one result item
// per input leaves on o_out (five contact flags, five Q16.8 filter values and
// hold_active). Both are valid/ready channels, an item moves when both are high.
// Kind 0 runs all five filters in parallel lanes and updates the contact
// latches unless a hold window is open; kind 1 opens a hold window of
// hold_ticks ticks and clears the latches; kind 2 counts the window down.
// Throughput is one item per cycle while i_in.ready is high: each lane's
// filter state feeds back through one 26x17 multiply, round and saturate
// combinationally, and the result is registered when the item is accepted.
// Results enter a two-entry queue; i_in.ready stays high while a stalled
// receiver leaves one slot free and drops only when both slots hold results.
// No result is dropped or repeated under stalls.
// Reset (i_rst_n low, synchronous) clears the filter states, previous samples,
// latches, hold count and queue, and loads the register defaults. Registers
// are written through the APB port, pready is always high.
`default_nettype none

module tactile_highpass_contact_detect import thcd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    thcd_in_if.sink                   i_in,
    thcd_out_if.source                o_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    t_cfg                   cfg;
    t_lane_ctrl             ctrl;
    t_sample [LANES-1:0]    samples;
    t_filt   [LANES-1:0]    y_next;
    logic    [LANES-1:0]    latch_next;
    logic    [LANES-1:0]    latch_cur;

    logic [HOLD_BITS-1:0]   r_hold;
    logic [HOLD_BITS-1:0]   n_hold;
    logic                   hold_zero;
    logic                   accept;
    logic                   pop;
    t_result                result;

    t_result                r_q0;
    t_result                r_q1;
    logic                   r_v0;
    logic                   r_v1;

    thcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign samples[0] = i_in.sample_a;
    assign samples[1] = i_in.sample_b;
    assign samples[2] = i_in.sample_c;
    assign samples[3] = i_in.sample_d;
    assign samples[4] = i_in.sample_e;

    assign i_in.ready = ~r_v1;
    assign accept     = i_in.valid & i_in.ready;
    assign hold_zero  = (r_hold == '0);

    always_comb begin
        ctrl.step      = accept;
        ctrl.sample_en = 1'b0;
        ctrl.latch_en  = 1'b0;
        ctrl.latch_clr = 1'b0;
        n_hold         = r_hold;
        unique case (i_in.kind)
            KIND_SAMPLE: begin
                ctrl.sample_en = 1'b1;
                ctrl.latch_en  = hold_zero;
            end
            KIND_TERM: begin
                ctrl.latch_clr = 1'b1;
                n_hold         = cfg.hold_ticks;
            end
            KIND_TICK: begin
                if (!hold_zero) begin
                    ctrl.latch_clr = 1'b1;
                    n_hold         = r_hold - HOLD_BITS'(1);
                end
            end
            KIND_NONE: begin
                n_hold = r_hold;
            end
            default: begin
                n_hold = r_hold;
            end
        endcase
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        thcd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_cfg        (cfg),
            .i_sample     (samples[g]),
            .o_y_next     (y_next[g]),
            .o_latch_next (latch_next[g]),
            .o_latch      (latch_cur[g])
        );
    end

    // merge lane results into one item
    assign result.contact     = latch_next;
    assign result.filtered    = y_next;
    assign result.hold_active = (n_hold != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (accept) begin
            r_hold <= n_hold;
        end
    end

    // two-entry result queue, head in r_q0
    assign pop = r_v0 & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (pop) begin
            if (r_v1) begin
                r_v1 <= accept;
            end else begin
                r_v0 <= accept;
            end
        end else if (accept) begin
            if (r_v0) begin
                r_v1 <= 1'b1;
            end else begin
                r_v0 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_v1) begin
                r_q0 <= r_q1;
                r_q1 <= result;
            end else begin
                r_q0 <= result;
            end
        end else if (accept) begin
            if (r_v0) begin
                r_q1 <= result;
            end else begin
                r_q0 <= result;
            end
        end
    end

    assign o_out.valid       = r_v0;
    assign o_out.contact_a   = r_q0.contact[0];
    assign o_out.contact_b   = r_q0.contact[1];
    assign o_out.contact_c   = r_q0.contact[2];
    assign o_out.contact_d   = r_q0.contact[3];
    assign o_out.contact_e   = r_q0.contact[4];
    assign o_out.filtered_a  = r_q0.filtered[0];
    assign o_out.filtered_b  = r_q0.filtered[1];
    assign o_out.filtered_c  = r_q0.filtered[2];
    assign o_out.filtered_d  = r_q0.filtered[3];
    assign o_out.filtered_e  = r_q0.filtered[4];
    assign o_out.hold_active = r_q0.hold_active;

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("queue tail valid without head");

    a_term_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_TERM) |=> (r_hold == $past(cfg.hold_ticks)))
        else $error("hold count not loaded on terminate");

    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold != '0) |-> (latch_cur == '0))
        else $error("contact latch set during hold window");

    a_tick_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_TICK && r_hold != '0)
            |=> (r_hold == $past(r_hold) - HOLD_BITS'(1)))
        else $error("hold count not decremented on tick");

endmodule

`default_nettype wire

### verif/tactile_highpass_contact_detect_checker.sv
// Watches the contact detector's channels and config port, predicts every result and checks it.
`default_nettype none

module tactile_highpass_contact_detect_checker import thcd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    thcd_in_if                        in_ch,
    thcd_out_if                       out_ch,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic                 i_pready,
    input  wire logic [ADDR_BITS-1:0] i_paddr,
    input  wire logic [DATA_BITS-1:0] i_pwdata,
    output int                        o_fail_count,
    output int                        o_pending
);

    // shadow registers
    logic [ALPHA_BITS-1:0]      alpha_q;
    logic signed [THR_BITS-1:0] set_thr_q;
    logic signed [THR_BITS-1:0] rel_thr_q;
    logic [HOLD_BITS-1:0]       hold_len_q;

    // shadow lane state
    t_sample          prev_x [LANES];
    t_filt            filt_y [LANES];
    logic [LANES-1:0] latch;
    logic [HOLD_BITS-1:0] hold_cnt;

    t_result expected_frames [$];
    int      mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    // y' = round(alpha * (y + (x - xp) * 2^8) / 2^16), saturated to 24 bits
    function automatic t_filt highpass_next(t_filt y, t_sample x, t_sample xp,
                                            logic [ALPHA_BITS-1:0] a);
        logic signed [26:0] acc;
        logic signed [26:0] delta;
        logic signed [44:0] prod;
        acc   = y;
        delta = x;
        delta = delta - xp;
        acc   = acc + (delta <<< FRAC_BITS);
        prod  = $signed({1'b0, a}) * acc;
        prod  = (prod + 45'sd32768) >>> 16;
        if (prod > 45'sd8388607)
            return 24'sh7FFFFF;
        if (prod < -45'sd8388608)
            return 24'sh800000;
        return prod[FILT_BITS-1:0];
    endfunction

    function automatic t_result step_detector(logic [KIND_BITS-1:0] kind, t_sample x [LANES]);
        t_result r;
        int      yv;
        int      set_lim;
        int      rel_lim;
        set_lim = set_thr_q;
        set_lim = set_lim * (1 << FRAC_BITS);
        rel_lim = rel_thr_q;
        rel_lim = rel_lim * (1 << FRAC_BITS);
        case (kind)
            KIND_SAMPLE: begin
                for (int i = 0; i < LANES; i++) begin
                    filt_y[i] = highpass_next(filt_y[i], x[i], prev_x[i], alpha_q);
                    prev_x[i] = x[i];
                    yv = filt_y[i];
                    // latches freeze while the hold window is open
                    if (hold_cnt == '0) begin
                        if (yv < set_lim)
                            latch[i] = 1'b1;
                        if (latch[i] && yv > rel_lim)
                            latch[i] = 1'b0;
                    end
                end
            end
            KIND_TERM: begin
                hold_cnt = hold_len_q;
                latch    = '0;
            end
            KIND_TICK: begin
                if (hold_cnt != '0) begin
                    latch    = '0;
                    hold_cnt = hold_cnt - 1'b1;
                end
            end
            default: ;
        endcase
        r.contact = latch;
        for (int i = 0; i < LANES; i++)
            r.filtered[i] = filt_y[i];
        r.hold_active = (hold_cnt != '0);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_sample lane_x [LANES];
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            alpha_q    = ALPHA_RESET;
            set_thr_q  = SET_RESET;
            rel_thr_q  = REL_RESET;
            hold_len_q = HOLD_RESET;
            for (int i = 0; i < LANES; i++) begin
                prev_x[i] = '0;
                filt_y[i] = '0;
            end
            latch    = '0;
            hold_cnt = '0;
            expected_frames.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                lane_x[0] = in_ch.sample_a;
                lane_x[1] = in_ch.sample_b;
                lane_x[2] = in_ch.sample_c;
                lane_x[3] = in_ch.sample_d;
                lane_x[4] = in_ch.sample_e;
                expected_frames.push_back(step_detector(in_ch.kind, lane_x));
            end
            if (out_ch.valid && out_ch.ready) begin
                got.contact = {out_ch.contact_e, out_ch.contact_d, out_ch.contact_c,
                               out_ch.contact_b, out_ch.contact_a};
                got.filtered[0] = out_ch.filtered_a;
                got.filtered[1] = out_ch.filtered_b;
                got.filtered[2] = out_ch.filtered_c;
                got.filtered[3] = out_ch.filtered_d;
                got.filtered[4] = out_ch.filtered_e;
                got.hold_active = out_ch.hold_active;
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    for (int i = 0; i < LANES; i++) begin
                        if (got.contact[i] !== want.contact[i]) begin
                            $display("%0t: contact lane %0d expected %0b got %0b", $time, i,
                                     want.contact[i], got.contact[i]);
                            mismatches++;
                        end
                        if (got.filtered[i] !== want.filtered[i]) begin
                            $display("%0t: filtered lane %0d expected %0d got %0d", $time, i,
                                     $signed(want.filtered[i]), $signed(got.filtered[i]));
                            mismatches++;
                        end
                    end
                    if (got.hold_active !== want.hold_active) begin
                        $display("%0t: hold_active expected %0b got %0b", $time,
                                 want.hold_active, got.hold_active);
                        mismatches++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_BITS-1:2])
                    REG_ALPHA:   alpha_q    = i_pwdata[ALPHA_BITS-1:0];
                    REG_SET:     set_thr_q  = i_pwdata[THR_BITS-1:0];
                    REG_RELEASE: rel_thr_q  = i_pwdata[THR_BITS-1:0];
                    REG_HOLD:    hold_len_q = i_pwdata[HOLD_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_frames.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

### verif/tactile_highpass_contact_detect_test.sv
// Stimulus, clock, reset and verdict for the tactile high-pass contact detector.
`default_nettype none

module tactile_highpass_contact_detect_test;
    import thcd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 29;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    thcd_in_if  in_ch ();
    thcd_out_if out_ch ();

    int      mismatch_total;
    int      pending_frames;
    int      quiet_cycles = 0;
    logic    idle_on = 1'b1;
    t_sample last_x [LANES];

    tactile_highpass_contact_detect DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tactile_highpass_contact_detect_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatch_total),
        .o_pending    (pending_frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_sample pick_sample(t_sample prev);
        int d;
        case ($urandom_range(7))
            0, 1:    return t_sample'($urandom_range(16'hFFFF));
            2:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: begin
                // small random walk keeps the filter near the thresholds
                d = $urandom_range(400);
                d = d - 200 + int'(prev);
                return t_sample'(d);
            end
        endcase
    endfunction

    function automatic t_sample near_zero(int span);
        int v;
        v = $urandom_range(2 * span);
        return t_sample'(v - span);
    endfunction

    task automatic send_item(input logic [KIND_BITS-1:0] k,
                             input t_sample sa, input t_sample sb, input t_sample sc,
                             input t_sample sd, input t_sample se);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid    = 1'b0;
            in_ch.kind     = KIND_BITS'($urandom_range(3));
            in_ch.sample_a = t_sample'($urandom_range(16'hFFFF));
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.kind     = k;
        in_ch.sample_a = sa;
        in_ch.sample_b = sb;
        in_ch.sample_c = sc;
        in_ch.sample_d = sd;
        in_ch.sample_e = se;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic send_all(input logic [KIND_BITS-1:0] k, input t_sample v);
        send_item(k, v, v, v, v, v);
    endtask

    task automatic send_junk(input logic [KIND_BITS-1:0] k);
        send_item(k, t_sample'($urandom_range(16'hFFFF)), t_sample'($urandom_range(16'hFFFF)),
                  t_sample'($urandom_range(16'hFFFF)), t_sample'($urandom_range(16'hFFFF)),
                  t_sample'($urandom_range(16'hFFFF)));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_frames != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [ALPHA_BITS-1:0] a, input logic signed [THR_BITS-1:0] s,
                             input logic signed [THR_BITS-1:0] r, input logic [HOLD_BITS-1:0] h);
        drain();
        write_reg(REG_ALPHA, DATA_BITS'(a));
        write_reg(REG_SET, DATA_BITS'(s));
        write_reg(REG_RELEASE, DATA_BITS'(r));
        write_reg(REG_HOLD, DATA_BITS'(h));
    endtask

    task automatic run_random(input int count);
        int                   r;
        logic [KIND_BITS-1:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 68)
                k = KIND_SAMPLE;
            else if (r < 73)
                k = KIND_TERM;
            else if (r < 95)
                k = KIND_TICK;
            else
                k = KIND_NONE;
            for (int i = 0; i < LANES; i++)
                last_x[i] = pick_sample(last_x[i]);
            send_item(k, last_x[0], last_x[1], last_x[2], last_x[3], last_x[4]);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_SAMPLE;
        in_ch.sample_a = '0;
        in_ch.sample_b = '0;
        in_ch.sample_c = '0;
        in_ch.sample_d = '0;
        in_ch.sample_e = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        for (int i = 0; i < LANES; i++)
            last_x[i] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, register defaults
        send_all(KIND_SAMPLE, 16'sd0);
        send_all(KIND_SAMPLE, 16'sh7FFF);
        send_all(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1, 16'sd1);
        send_all(KIND_SAMPLE, -16'sd1000);
        send_all(KIND_SAMPLE, 16'sd1000);
        send_all(KIND_SAMPLE, 16'sd900);
        send_junk(KIND_TERM);                 // terminate ignores its samples
        send_all(KIND_SAMPLE, 16'sd500);      // frame inside the hold window
        send_junk(KIND_TICK);
        send_junk(KIND_NONE);                 // unused kind
        // short hold window, then a tick with no hold
        configure(ALPHA_RESET, SET_RESET, REL_RESET, 10'd2);
        send_all(KIND_TERM, 16'sd0);
        send_all(KIND_TICK, 16'sd0);
        send_all(KIND_TICK, 16'sd0);
        send_all(KIND_TICK, 16'sd0);
        send_all(KIND_SAMPLE, 16'sd0);
        // terminate with a zero-length hold still clears the latches
        configure(ALPHA_RESET, SET_RESET, REL_RESET, 10'd0);
        send_all(KIND_SAMPLE, -16'sd500);
        send_all(KIND_TERM, 16'sd0);
        send_all(KIND_SAMPLE, -16'sd1000);
        // full-scale swings with alpha near one saturate both ends
        configure(16'hFFFF, 16'sh8000, 16'sh7FFF, 10'd100);
        send_all(KIND_SAMPLE, 16'sh7FFF);
        send_all(KIND_SAMPLE, 16'sh8000);
        send_all(KIND_SAMPLE, 16'sd0);
        send_all(KIND_SAMPLE, 16'sh8000);
        send_all(KIND_SAMPLE, 16'sh7FFF);

        // random phases
        configure(ALPHA_RESET, SET_RESET, REL_RESET, 10'd5);
        run_random(150);
        configure(16'hFFFF, 16'sh8000, 16'sh7FFF, 10'd0);
        run_random(150);
        configure(16'h0000, 16'sh7FFF, 16'sh8000, 10'h3FF);
        run_random(100);
        configure(16'($urandom_range(16'hFFFF)), near_zero(300), near_zero(300),
                  10'($urandom_range(15)));
        run_random(80);
        drain();                              // sender holds off until all results are in
        run_random(70);
        configure(16'h8000, near_zero(2000), near_zero(2000), 10'd1);
        run_random(150);
        idle_on = 1'b0;                       // back-to-back stretch on both sides
        configure(16'($urandom_range(16'hFFFF)), -16'sd100, 16'sd50, 10'd20);
        run_random(150);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### tactile_highpass_contact_detect.f
hw/rtl/thcd_pkg.sv
hw/rtl/thcd_if.sv
hw/rtl/thcd_regs.sv
hw/rtl/thcd_lane.sv
hw/rtl/tactile_highpass_contact_detect.sv
verif/tactile_highpass_contact_detect_checker.sv
verif/tactile_highpass_contact_detect_test.sv
